// ----- hdl/shared_dual_stack_core_macros.svh -----
// Assertion macros shared by the stack core files.
`ifndef SHARED_DUAL_STACK_CORE_MACROS_SVH
`define SHARED_DUAL_STACK_CORE_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define SDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stack core check failed");

// Next-cycle implication.
`define SDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stack core check failed");

`endif

// ----- hdl/sds_pkg.sv -----
// Types and constants for the shared dual stack core.
package sds_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic {
    SIDE_LOW  = 1'b0,
    SIDE_HIGH = 1'b1
  } side_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // One classified request, handed from the front to the back.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    status_t           status;
    logic              low_empty;
    logic              high_empty;
    logic              full;
  } cmd_t;

endpackage

// ----- hdl/shared_dual_stack_core.sv -----
// A request passes through the command queue, the access stage and the output register.
// Throughput: one request per cycle while results are taken; the single store port takes one access a cycle.
// A four-entry command queue lets the request side run ahead of a stalled result side.
// Reset (rst, synchronous, active high) empties both stacks, the queue and the output.
// Store contents are not cleared; a word is only read after a push has written it.
module shared_dual_stack_core
  import sds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,  // push_value
  input  logic [1:0]        s_tuser,  // opcode, side
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,  // pop_value
  output logic [4:0]        m_tuser   // status[1:0], low_empty, high_empty, full_flag
);

  logic f_valid;
  cmd_t f_cmd;
  logic f_ready;
  logic b_valid;
  cmd_t b_cmd;
  logic b_pop;

  sds_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_ready  (f_ready),
    .q_valid  (f_valid),
    .q_cmd    (f_cmd)
  );

  sds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid),
    .push_cmd   (f_cmd),
    .push_ready (f_ready),
    .pop        (b_pop),
    .pop_valid  (b_valid),
    .pop_cmd    (b_cmd)
  );

  sds_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (b_valid),
    .q_cmd    (b_cmd),
    .q_pop    (b_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- hdl/sds_ram.sv -----
// Generic single-port RAM with registered read.
module sds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- hdl/sds_front.sv -----
// Front end: takes requests, checks them against the counts, builds commands.
`include "shared_dual_stack_core_macros.svh"

module sds_front
  import sds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,
  input  logic [1:0]        s_tuser,
  input  logic              q_ready,
  output logic              q_valid,
  output cmd_t              q_cmd
);

  logic [CNT_W-1:0] low_count, low_count_next;
  logic [CNT_W-1:0] high_count, high_count_next;
  logic [CNT_W:0]   sum_now, sum_next;
  logic             full_now;
  logic             accept;
  op_t              op;
  side_t            side;

  assign s_tready = q_ready;
  assign accept   = s_tvalid && s_tready;
  assign q_valid  = accept;
  assign op       = op_t'(s_tuser[0]);
  assign side     = side_t'(s_tuser[1]);

  assign sum_now  = {1'b0, low_count} + {1'b0, high_count};
  assign full_now = sum_now >= (CNT_W+1)'(DEPTH);

  always_comb begin
    low_count_next  = low_count;
    high_count_next = high_count;
    q_cmd           = '0;
    q_cmd.wdata     = s_tdata;
    q_cmd.status    = ST_DONE;
    unique case (op)
      OP_PUSH: begin
        if (full_now) begin
          q_cmd.status = ST_OVERFLOW;
        end else if (side == SIDE_LOW) begin
          q_cmd.wr_en    = 1'b1;
          q_cmd.addr     = low_count[ADDR_W-1:0];
          low_count_next = low_count + CNT_W'(1);
        end else begin
          q_cmd.wr_en     = 1'b1;
          q_cmd.addr      = ADDR_W'(CNT_W'(DEPTH - 1) - high_count);
          high_count_next = high_count + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (side == SIDE_LOW) begin
          if (low_count == '0) begin
            q_cmd.status = ST_UNDERFLOW;
          end else begin
            q_cmd.rd_en    = 1'b1;
            low_count_next = low_count - CNT_W'(1);
            q_cmd.addr     = low_count_next[ADDR_W-1:0];
          end
        end else begin
          if (high_count == '0) begin
            q_cmd.status = ST_UNDERFLOW;
          end else begin
            q_cmd.rd_en     = 1'b1;
            high_count_next = high_count - CNT_W'(1);
            // DEPTH-1-(high_count-1)
            q_cmd.addr      = ADDR_W'(CNT_W'(DEPTH) - high_count);
          end
        end
      end
      default: ;
    endcase
    sum_next         = {1'b0, low_count_next} + {1'b0, high_count_next};
    q_cmd.low_empty  = (low_count_next == '0);
    q_cmd.high_empty = (high_count_next == '0);
    q_cmd.full       = sum_next >= (CNT_W+1)'(DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_count  <= '0;
      high_count <= '0;
    end else if (accept) begin
      low_count  <= low_count_next;
      high_count <= high_count_next;
    end
  end

  `SDS_ASSERT_NOW(a_sum_bound, 1'b1, sum_now <= (CNT_W+1)'(DEPTH))
  `SDS_ASSERT_NEXT(a_low_push_inc, accept && op == OP_PUSH && side == SIDE_LOW && !full_now, low_count == $past(low_count) + CNT_W'(1))
  `SDS_ASSERT_NEXT(a_reject_holds, accept && q_cmd.status != ST_DONE, low_count == $past(low_count) && high_count == $past(high_count))

endmodule

// ----- hdl/sds_queue.sv -----
// Short command FIFO between front and back.
`include "shared_dual_stack_core_macros.svh"

module sds_queue
  import sds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign push_ready = fill != QCNT_W'(QDEPTH);
  assign pop_valid  = fill != '0;
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: ;
      endcase
    end
  end

  `SDS_ASSERT_NOW(a_pop_nonempty, pop, fill != '0)
  `SDS_ASSERT_NOW(a_push_room, push, fill != QCNT_W'(QDEPTH))

endmodule

// ----- hdl/sds_back.sv -----
// Back end: runs commands against the shared store and holds the result.
module sds_back
  import sds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,
  output logic [4:0]        m_tuser
);

  logic              a_valid;
  cmd_t              a_cmd;
  logic              move_a;
  logic              issue;
  logic [DATA_W-1:0] rdata;

  assign move_a = a_valid && (!m_tvalid || m_tready);
  assign issue  = q_valid && (!a_valid || move_a);
  assign q_pop  = issue;

  sds_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (issue && q_cmd.wr_en),
    .re    (issue && q_cmd.rd_en),
    .addr  (q_cmd.addr),
    .wdata (q_cmd.wdata),
    .rdata (rdata)
  );

  // read data holds while the access stage waits, as re stays low
  always_ff @(posedge clk) begin
    if (issue) begin
      a_cmd <= q_cmd;
    end
    if (move_a) begin
      m_tdata <= a_cmd.rd_en ? rdata : '0;
      m_tuser <= {a_cmd.full, a_cmd.high_empty, a_cmd.low_empty, a_cmd.status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (issue) begin
        a_valid <= 1'b1;
      end else if (move_a) begin
        a_valid <= 1'b0;
      end
      if (move_a) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
